// ===== hw/rtl/stm_pkg.sv =====
// shared types and constants of the stereo track mixer
// used by stm_ctrl, stm_dp and stereo_track_mixer_with_fade; depends on nothing
package stm_pkg;

    // track store and fade ramp
    localparam int TRACK_DEPTH = 16384;
    localparam int FADE_LENGTH = 11025;
    localparam int ADDR_W      = $clog2(TRACK_DEPTH);

    // field widths
    localparam int CMD_W      = 2;
    localparam int LOAD_W     = 14;
    localparam int SMP_W      = 16;
    localparam int FRAME_W    = 2 * SMP_W;
    localparam int POS_W      = 15;
    localparam int FADE_W     = 14;
    localparam int VOL_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // arithmetic widths
    localparam int GPROD_W = VOL_W + FADE_W;   // volume times elapsed fade
    localparam int MAG_W   = SMP_W + 1;        // sample magnitude, holds 32768
    localparam int MPROD_W = MAG_W + VOL_W;    // magnitude times gain
    localparam int QUO_W   = SMP_W;            // quotient of the percent scaling
    localparam int SUM_W   = SMP_W + 2;

    localparam logic [VOL_W-1:0]          VOL_MAX   = VOL_W'(100);
    localparam logic [VOL_W-1:0]          PCT_SCALE = VOL_W'(100);
    localparam logic signed [SMP_W-1:0]   SMP_MAX   = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0]   SMP_MIN   = 16'sh8000;
    localparam logic [FADE_W-1:0]         FADE_INIT = FADE_W'(FADE_LENGTH);
    localparam logic [POS_W-1:0]          LEN_CAP   = POS_W'(TRACK_DEPTH);

    // reciprocals for division by constants: floor(2^32 / d), one correction step after
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned FADE_RECIP_VAL = (64'd1 << RECIP_SHIFT) / FADE_LENGTH;
    localparam int FADE_RECIP_W = $clog2(FADE_RECIP_VAL + 1);
    localparam logic [FADE_RECIP_W-1:0] FADE_RECIP = FADE_RECIP_W'(FADE_RECIP_VAL);
    localparam longint unsigned PCT_RECIP_VAL = (64'd1 << RECIP_SHIFT) / 100;
    localparam int PCT_RECIP_W = $clog2(PCT_RECIP_VAL + 1);
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(PCT_RECIP_VAL);

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MIX     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [LOAD_W-1:0]       load_address;
        logic signed [SMP_W-1:0] track_left;
        logic signed [SMP_W-1:0] track_right;
        logic signed [SMP_W-1:0] bus_left;
        logic signed [SMP_W-1:0] bus_right;
    } stm_in_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] mixed_left;
        logic signed [SMP_W-1:0] mixed_right;
        logic                    track_added;
        logic [POS_W-1:0]        position_now;
    } stm_out_t;

    typedef struct packed {
        logic             play_enable;
        logic [VOL_W-1:0] volume;
        logic             loop_enable;
        logic [POS_W-1:0] track_length;
    } stm_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic gain_mul;
        logic gain_fix;
        logic prod;
        logic div_mul;
        logic div_fix;
        logic out_load;
    } stm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mix_go;
        logic fading;
        logic out_free;
    } stm_status_t;

endpackage

// ===== hw/rtl/stm_ctrl.sv =====
// sequencing state machine of the stereo track mixer
// depends on stm_pkg; drives the command struct of stm_dp
module stm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  stm_pkg::stm_status_t status,
    output stm_pkg::stm_cmd_t    cmd
);
    import stm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_GMUL = 7'b0000010,
        ST_GFIX = 7'b0000100,
        ST_PROD = 7'b0001000,
        ST_DMUL = 7'b0010000,
        ST_DFIX = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (!status.mix_go)
                        state_next = ST_OUT;
                    else if (status.fading)
                        state_next = ST_GMUL;
                    else
                        state_next = ST_PROD;
                end
            end
            ST_GMUL:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = ST_GFIX;
            end
            ST_GFIX:
            begin
                cmd.gain_fix = 1'b1;
                state_next   = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_DFIX;
            end
            ST_DFIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/stm_dp.sv =====
// datapath of the stereo track mixer: track store, position and fade state,
// gain and scaling arithmetic, output register; depends on stm_pkg
module stm_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stm_pkg::stm_cfg_t    cfg,
    input  stm_pkg::stm_in_t     item,
    input  stm_pkg::stm_cmd_t    cmd,
    output stm_pkg::stm_status_t status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output stm_pkg::stm_out_t    result
);
    import stm_pkg::*;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_MIX
    } mode_t;

    localparam int GFULL_W = GPROD_W + FADE_RECIP_W;
    localparam int DFULL_W = MPROD_W + PCT_RECIP_W;

    // track store, no reset
    logic [FRAME_W-1:0] track_mem [TRACK_DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;

    // control state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [FADE_W-1:0] fade_reg;
    logic [FADE_W-1:0] fade_next;
    logic              result_valid_reg;

    // item payload
    mode_t                   mode_reg;
    logic signed [SMP_W-1:0] bus_reg [2];

    // gain
    logic [GPROD_W-1:0] gprod_reg;
    logic [VOL_W-1:0]   gq0_reg;
    logic [VOL_W-1:0]   gain_reg;
    logic [GFULL_W-1:0] gain_full;
    logic [GPROD_W-1:0] gain_rem;

    // per-lane scaling
    logic [MAG_W-1:0]        mag    [2];
    logic                    sign_reg [2];
    logic [MPROD_W-1:0]      mprod_reg [2];
    logic [DFULL_W-1:0]      div_full [2];
    logic [QUO_W-1:0]        q0_reg [2];
    logic [MPROD_W-1:0]      div_rem [2];
    logic [QUO_W-1:0]        q_reg [2];
    logic signed [MAG_W-1:0] sq [2];
    logic signed [SUM_W-1:0] sum [2];
    logic signed [SMP_W-1:0] mixed [2];
    logic signed [SMP_W-1:0] smp [2];

    stm_out_t result_reg;
    stm_out_t result_next;

    // decision for a mix item
    logic [VOL_W-1:0] vol_eff;
    logic [POS_W-1:0] len_eff;
    logic             go_base;
    logic             at_end;
    logic             wrap;
    logic             go_now;
    logic             fading_now;
    logic [POS_W-1:0] rd_pos;

    assign vol_eff    = (cfg.volume > VOL_MAX) ? VOL_MAX : cfg.volume;
    assign len_eff    = (cfg.track_length > LEN_CAP) ? LEN_CAP : cfg.track_length;
    assign go_base    = cfg.play_enable && (len_eff != '0) && (vol_eff != '0);
    assign at_end     = (pos_reg >= len_eff);
    assign wrap       = go_base && at_end && cfg.loop_enable;
    assign go_now     = (item.command == CMD_MIX) && go_base && (!at_end || cfg.loop_enable);
    assign fading_now = (fade_reg != '0);
    assign rd_pos     = wrap ? '0 : pos_reg;

    assign status.mix_go   = go_now;
    assign status.fading   = fading_now;
    assign status.out_free = !result_valid_reg || !result_stall;

    assign mem_we = cmd.take_item && (item.command == CMD_LOAD)
                    && (int'(item.load_address) < TRACK_DEPTH);
    assign mem_re = cmd.take_item && go_now;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            track_mem[item.load_address[ADDR_W-1:0]] <= {item.track_right, item.track_left};
        if (mem_re)
            rd_data_reg <= track_mem[rd_pos[ADDR_W-1:0]];
    end

    // position and fade updates happen when the item is taken
    always_comb
    begin
        pos_next  = pos_reg;
        fade_next = fade_reg;
        if (cmd.take_item)
        begin
            unique case (item.command)
                CMD_RESTART:
                begin
                    pos_next  = '0;
                    fade_next = FADE_INIT;
                end
                CMD_MIX:
                begin
                    if (go_now)
                    begin
                        pos_next = rd_pos + 1'b1;
                        if (fading_now)
                            fade_next = fade_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            fade_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fade_reg <= fade_next;
            if (cmd.out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // fade gain: vol * (fade - remaining) / fade via reciprocal and one correction
    assign gain_full = GFULL_W'(gprod_reg) * GFULL_W'(FADE_RECIP);
    assign gain_rem  = gprod_reg - GPROD_W'(GPROD_W'(gq0_reg) * GPROD_W'(FADE_INIT));

    // per-lane magnitude, percent scaling and saturating add
    always_comb
    begin
        smp[0] = rd_data_reg[SMP_W-1:0];
        smp[1] = rd_data_reg[FRAME_W-1:SMP_W];
        for (int i = 0; i < 2; i++)
        begin
            if (smp[i][SMP_W-1])
                mag[i] = ~{1'b1, smp[i]} + 1'b1;
            else
                mag[i] = {1'b0, smp[i]};
            div_full[i] = DFULL_W'(mprod_reg[i]) * DFULL_W'(PCT_RECIP);
            div_rem[i]  = mprod_reg[i] - MPROD_W'(MPROD_W'(q0_reg[i]) * MPROD_W'(PCT_SCALE));
            if (sign_reg[i])
                sq[i] = -$signed({1'b0, q_reg[i]});
            else
                sq[i] = $signed({1'b0, q_reg[i]});
            sum[i] = SUM_W'(bus_reg[i]) + SUM_W'(sq[i]);
            if (sum[i] > SUM_W'(SMP_MAX))
                mixed[i] = SMP_MAX;
            else if (sum[i] < SUM_W'(SMP_MIN))
                mixed[i] = SMP_MIN;
            else
                mixed[i] = sum[i][SMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            bus_reg[0] <= item.bus_left;
            bus_reg[1] <= item.bus_right;
            gprod_reg  <= GPROD_W'(GPROD_W'(vol_eff) * GPROD_W'(FADE_INIT - fade_reg));
            gain_reg   <= vol_eff;
            if (item.command != CMD_MIX)
                mode_reg <= MODE_ZERO;
            else if (go_now)
                mode_reg <= MODE_MIX;
            else
                mode_reg <= MODE_PASS;
        end
        if (cmd.gain_mul)
            gq0_reg <= gain_full[RECIP_SHIFT +: VOL_W];
        if (cmd.gain_fix)
            gain_reg <= (gain_rem >= GPROD_W'(FADE_INIT)) ? gq0_reg + 1'b1 : gq0_reg;
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.prod)
            begin
                mprod_reg[i] <= MPROD_W'(mag[i]) * MPROD_W'(gain_reg);
                sign_reg[i]  <= smp[i][SMP_W-1];
            end
            if (cmd.div_mul)
                q0_reg[i] <= div_full[i][RECIP_SHIFT +: QUO_W];
            if (cmd.div_fix)
                q_reg[i] <= (div_rem[i] >= MPROD_W'(PCT_SCALE)) ? q0_reg[i] + 1'b1 : q0_reg[i];
        end
        if (cmd.out_load)
            result_reg <= result_next;
    end

    always_comb
    begin
        result_next.position_now = pos_reg;
        case (mode_reg)
            MODE_MIX:
            begin
                result_next.mixed_left  = mixed[0];
                result_next.mixed_right = mixed[1];
                result_next.track_added = 1'b1;
            end
            MODE_PASS:
            begin
                result_next.mixed_left  = bus_reg[0];
                result_next.mixed_right = bus_reg[1];
                result_next.track_added = 1'b0;
            end
            default:
            begin
                result_next.mixed_left  = '0;
                result_next.mixed_right = '0;
                result_next.track_added = 1'b0;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/stereo_track_mixer_with_fade.sv =====
// stereo track mixer with linear fade-in: top level, configuration registers
// load, restart and pass-through items go from acceptance straight to the output register;
// a mix item first passes the product, percent-scaling multiply and correction steps, and
// during a fade the fade-gain multiply and correction steps before those; the output register
// loads only when it is free, and the next item is taken only once the result has been loaded
// reset: position and fade counter cleared, registers to defaults, track store not cleared
module stereo_track_mixer_with_fade (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  stm_pkg::stm_in_t                     item,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output stm_pkg::stm_out_t                    result,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import stm_pkg::*;

    stm_cfg_t    cfg_reg;
    stm_cmd_t    cmd;
    stm_status_t status;

    // the user must write configuration only while the block is idle; the block does not enforce it, so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_enable  <= 1'b0;
            cfg_reg.volume       <= VOL_W'(85);
            cfg_reg.loop_enable  <= 1'b1;
            cfg_reg.track_length <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLAY_ENABLE:  cfg_reg.play_enable  <= cfg_data[0];
                REG_VOLUME:       cfg_reg.volume       <= cfg_data[VOL_W-1:0];
                REG_LOOP_ENABLE:  cfg_reg.loop_enable  <= cfg_data[0];
                REG_TRACK_LENGTH: cfg_reg.track_length <= cfg_data[POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: one item at a time, steps a mix item through gain (during a fade) and scaling
    stm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // track store, play position, fade counter, arithmetic and the output register
    stm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
